>>> rtl/core/mei_pkg.sv
// Shared types for the escape-time iteration core.
// Holds the controller states and the command and status records
// exchanged between the controller and the datapath.
package mei_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic finish;
    logic esc_val;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic big;
    logic sum_ge4;
  } status_t;

  localparam int unsigned REG_MAX_ITER = 0;
  localparam logic [15:0] MAX_ITER_RESET = 16'd256;

endpackage

>>> rtl/core/mei_ctrl.sv
// Controller state machine for the escape-time iteration core.
// Depends on mei_pkg for the state type and the command and status records.
module mei_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mei_pkg::status_t status,
  output mei_pkg::cmd_t    cmd
);

  mei_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mei_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      mei_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mei_pkg::ST_MUL;
        end
      end
      mei_pkg::ST_MUL: begin
        priority if (status.at_limit) begin
          cmd.finish  = 1'b1;
          cmd.esc_val = 1'b0;
          state_next  = mei_pkg::ST_DONE;
        end else if (status.big) begin
          cmd.finish  = 1'b1;
          cmd.esc_val = 1'b1;
          state_next  = mei_pkg::ST_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = mei_pkg::ST_UPD;
        end
      end
      mei_pkg::ST_UPD: begin
        if (status.sum_ge4) begin
          cmd.finish  = 1'b1;
          cmd.esc_val = 1'b1;
          state_next  = mei_pkg::ST_DONE;
        end else begin
          cmd.upd    = 1'b1;
          state_next = mei_pkg::ST_MUL;
        end
      end
      mei_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = mei_pkg::ST_IDLE;
        end
      end
      default: state_next = mei_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end
  end

endmodule

>>> rtl/core/mei_dp.sv
// Datapath for the escape-time iteration core: the z registers, the
// squaring multipliers, the escape tests, the counter and the result register.
// Depends on mei_pkg for the command and status records.
module mei_dp #(
  parameter int FRAC_BITS = 28,
  parameter int CNT_W     = 16
) (
  input  logic                    clk,
  input  mei_pkg::cmd_t           cmd,
  output mei_pkg::status_t        status,
  input  logic signed [31:0]      c_real,
  input  logic signed [31:0]      c_imag,
  input  logic        [CNT_W-1:0] limit,
  output logic        [15:0]      iteration_count,
  output logic                    escaped
);

  localparam int ZI = (FRAC_BITS + 3 > 31) ? FRAC_BITS + 3 : 31;
  localparam int ZW = ZI + 2;
  localparam int OW = FRAC_BITS + 2;
  localparam int PW = 2 * OW;

  localparam logic signed [ZW-1:0] TWO     = ZW'(64'd2 << FRAC_BITS);
  localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
  localparam logic signed [PW:0]   FOUR    = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  logic signed [31:0]   cr, ci;
  logic signed [ZW-1:0] zr, zi;
  logic [CNT_W-1:0]     count;
  logic signed [PW-1:0] rr, ii, ri;
  logic                 esc_flag;

  logic signed [OW-1:0] zr_n, zi_n;
  logic signed [PW:0]   sum;
  logic signed [PW-1:0] diff, re_sh;
  logic signed [PW:0]   dbl, im_sh;

  assign zr_n = zr[OW-1:0];
  assign zi_n = zi[OW-1:0];
  assign sum   = (PW + 1)'(rr) + (PW + 1)'(ii);
  assign diff  = rr - ii;
  assign dbl   = {ri, 1'b0};
  assign re_sh = diff >>> FRAC_BITS;
  assign im_sh = dbl >>> FRAC_BITS;

  assign status.at_limit = (count >= limit);
  assign status.big      = (zr >= TWO) || (zr <= NEG_TWO) || (zi >= TWO) || (zi <= NEG_TWO);
  assign status.sum_ge4  = (sum >= FOUR);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= c_real;
      ci    <= c_imag;
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.upd) begin
      zr    <= ZW'(re_sh) + ZW'(cr);
      zi    <= ZW'(im_sh) + ZW'(ci);
      count <= count + CNT_W'(1);
    end
    if (cmd.mul) begin
      rr <= zr_n * zr_n;
      ii <= zi_n * zi_n;
      ri <= zr_n * zi_n;
    end
    if (cmd.finish) begin
      esc_flag <= cmd.esc_val;
    end
    if (cmd.emit) begin
      iteration_count <= 16'(count);
      escaped         <= esc_flag;
    end
  end

endmodule

>>> rtl/core/mandelbrot_escape_iteration_core.sv
// Escape-time iteration core: each request carries one point c; the core
// iterates z = z*z + c and returns the iteration count and an escape flag.
// Each iteration runs a squaring step and then an update step, and one
// point is in work at a time. Reset sets max_iterations to 256 and returns
// the controller to idle.
module mandelbrot_escape_iteration_core #(
  parameter int FRAC_BITS = 28,
  parameter int ITER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] c_real,
  input  logic signed [31:0] c_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        iteration_count,
  output logic               escaped
);

  localparam int CNT_W = (ITER_BITS < 16) ? ITER_BITS : 16;
  localparam logic [CNT_W-1:0] CAP = '1;

  logic [15:0]      max_iterations;
  logic [CNT_W-1:0] limit;
  logic             reg_index;

  mei_pkg::cmd_t    cmd;
  mei_pkg::status_t status;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mei_pkg::MAX_ITER_RESET;
    end else if (psel && penable && pwrite
                 && (32'(reg_index) == mei_pkg::REG_MAX_ITER)) begin
      max_iterations <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(reg_index) == mei_pkg::REG_MAX_ITER) begin
      prdata = 32'(max_iterations);
    end
  end

  assign limit = (max_iterations > 16'(CAP)) ? CAP : max_iterations[CNT_W-1:0];

  mei_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mei_dp #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .limit           (limit),
    .iteration_count (iteration_count),
    .escaped         (escaped)
  );

endmodule

>>> tb/sv/tb_mandelbrot_escape_iteration_core.sv
// Self-checking testbench for mandelbrot_escape_iteration_core, driving points
// and the max_iterations register and checking each result against a predictor
// or a table of known answers. Depends on mei_pkg and the core RTL only.
module tb_mandelbrot_escape_iteration_core;

  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 16;
  localparam logic [2:0] MAX_ITER_ADDR = 3'(mei_pkg::REG_MAX_ITER * 4);
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_PHASES = 18;
  localparam int POINTS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT = 500000;
  localparam int REPORT_CAP = 50;

  typedef struct packed {
    logic [15:0] count;
    logic        escaped;
  } escape_result_t;

  typedef struct packed {
    logic [15:0] limit;
    logic [31:0] cr;
    logic [31:0] ci;
    logic        known;
    logic [15:0] count;
    logic        escaped;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        iteration_count;
  logic               escaped;

  escape_result_t pending_escapes[$];
  logic [15:0]    max_iter_now;
  int unsigned    mismatches;
  int unsigned    points_sent;
  int unsigned    results_seen;
  int unsigned    escapes_seen;
  int unsigned    limits_set;
  int unsigned    idle_cycles;

  // Known answers: reset limit, extreme components, -1 and 0 as bounded
  // orbits, zero limit, escape exactly at the limit, and the widest limit.
  stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    {16'd256,   32'h0000_0000, 32'h0000_0000, 1'b1, 16'd256,   1'b0},
    {16'd256,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd1,     1'b1},
    {16'd256,   32'h8000_0000, 32'h0000_0000, 1'b1, 16'd1,     1'b1},
    {16'd256,   32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 16'd1,     1'b1},
    {16'd256,   32'h0000_0000, 32'h8000_0000, 1'b1, 16'd1,     1'b1},
    {16'd256,   32'h8000_0000, 32'h8000_0000, 1'b1, 16'd1,     1'b1},
    {16'd256,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1,     1'b1},
    {16'd256,   32'hE000_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
    {16'd256,   32'hF000_0000, 32'h0000_0000, 1'b1, 16'd256,   1'b0},
    {16'd256,   32'h0000_0000, 32'h1000_0000, 1'b0, 16'd0,     1'b0},
    {16'd256,   32'h0400_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
    {16'd256,   32'h1FFF_FFFF, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
    {16'd256,   32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'd0,     1'b0},
    {16'd256,   32'h0600_0000, 32'h1000_0000, 1'b0, 16'd0,     1'b0},
    {16'd0,     32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
    {16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
    {16'd1,     32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd1,     1'b0},
    {16'd1,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd1,     1'b0},
    {16'd2,     32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd1,     1'b1},
    {16'd65535, 32'h4000_0000, 32'h0000_0000, 1'b1, 16'd1,     1'b1},
    {16'd65535, 32'h0800_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
    {16'd65535, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd65535, 1'b0}
  };

  mandelbrot_escape_iteration_core #(
    .FRAC_BITS(FRAC_BITS),
    .ITER_BITS(ITER_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .c_real(c_real),
    .c_imag(c_imag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .iteration_count(iteration_count),
    .escaped(escaped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic escape_result_t predict_escape(input logic signed [31:0] cr,
                                                    input logic signed [31:0] ci,
                                                    input logic [15:0] limit);
    longint two;
    longint four_sq;
    longint cr_ext;
    longint ci_ext;
    longint zr;
    longint zi;
    longint rr;
    longint ii;
    longint ri;
    int unsigned n;
    bit done;
    escape_result_t res;
    two = 64'sd2 <<< FRAC_BITS;
    four_sq = 64'sd4 <<< (2 * FRAC_BITS);
    cr_ext = cr;
    ci_ext = ci;
    zr = 0;
    zi = 0;
    n = 0;
    done = 1'b0;
    res.escaped = 1'b0;
    while (n < limit && !done) begin
      if (zr >= two || zr <= -two || zi >= two || zi <= -two) begin
        res.escaped = 1'b1;
        done = 1'b1;
      end else begin
        rr = zr * zr;
        ii = zi * zi;
        if (rr + ii >= four_sq) begin
          res.escaped = 1'b1;
          done = 1'b1;
        end else begin
          ri = zr * zi;
          zr = ((rr - ii) >>> FRAC_BITS) + cr_ext;
          zi = ((2 * ri) >>> FRAC_BITS) + ci_ext;
          n++;
        end
      end
    end
    res.count = n[15:0];
    return res;
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < REPORT_CAP)
      $display("mismatch on %s: got %0d, expected %0d (result %0d)",
               what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic pick_point(output logic [31:0] cr, output logic [31:0] ci);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      cr = $urandom;
      ci = $urandom;
    end else begin
      cr = $urandom_range(0, 32'h3800_0000) - 32'sh2800_0000;
      ci = $urandom_range(0, 32'h3000_0000) - 32'sh1800_0000;
    end
  endtask

  task automatic send_point(input logic [31:0] cr, input logic [31:0] ci,
                            input bit known, input escape_result_t want);
    c_real <= cr;
    c_imag <= ci;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_escapes.push_back(known ? want : predict_escape(cr, ci, max_iter_now));
    points_sent++;
  endtask

  task automatic wait_all_escapes(input int unsigned settle);
    in_valid <= 1'b0;
    while (pending_escapes.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_max_iterations(input logic [15:0] value);
    logic [15:0] junk;
    logic [31:0] readback;
    junk = 16'($urandom);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_ITER_ADDR;
    pwdata <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {16'h0000, value})
      report_mismatch("max_iterations readback", readback, 32'(value));
    max_iter_now = value;
    limits_set++;
  endtask

  always @(posedge clk) begin
    escape_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (escaped === 1'b1) escapes_seen++;
      if (pending_escapes.size() == 0) begin
        report_mismatch("unexpected request result", 32'(iteration_count), 0);
      end else begin
        want = pending_escapes.pop_front();
        if (iteration_count !== want.count)
          report_mismatch("iteration_count", 32'(iteration_count), 32'(want.count));
        if (escaped !== want.escaped)
          report_mismatch("escaped", 32'(escaped), 32'(want.escaped));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned r;
    int unsigned holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= 400 + 800 * holds_done) begin
        out_stall <= 1'b1;
        holds_done++;
        repeat (600) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(100, 300)) @(posedge clk);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (pick_length()) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [31:0] cr;
    logic [31:0] ci;
    logic [15:0] limit;
    int unsigned gap;
    bit steady;
    escape_result_t want;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    c_real = '0;
    c_imag = '0;
    mismatches = 0;
    points_sent = 0;
    results_seen = 0;
    escapes_seen = 0;
    limits_set = 0;
    idle_cycles = 0;
    max_iter_now = mei_pkg::MAX_ITER_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].limit != max_iter_now) begin
        wait_all_escapes(4);
        set_max_iterations(directed_rows[i].limit);
      end
      want.count = directed_rows[i].count;
      want.escaped = directed_rows[i].escaped;
      send_point(directed_rows[i].cr, directed_rows[i].ci, directed_rows[i].known, want);
      gap = ($urandom_range(0, 1) == 0) ? 0 : pick_length();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    want = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      r_limit: begin
        case ($urandom_range(0, 9))
          0: limit = 16'($urandom_range(0, 3));
          1: limit = 16'd256;
          2: limit = 16'($urandom_range(257, 1024));
          default: limit = 16'($urandom_range(1, 64));
        endcase
      end
      wait_all_escapes(4);
      set_max_iterations(limit);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < POINTS_PER_PHASE; k++) begin
        pick_point(cr, ci);
        send_point(cr, ci, 1'b0, want);
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_length();
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_all_escapes(16);
    $display("sent %0d points under %0d iteration limits; %0d results checked, %0d escaped",
             points_sent, limits_set, results_seen, escapes_seen);
    $display("mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
